// ===== sv/rtc_pkg.sv =====
// package for the rotate-about-center splat core
// word types, image size constants and fixed-point widths
// no dependencies
package rtc_pkg;

	localparam int IMAGE_WIDTH  = 512;
	localparam int IMAGE_HEIGHT = 512;
	localparam int FRAC_BITS    = 14;

	localparam int SRC_W   = 9;
	localparam int COLOR_W = 8;
	localparam int DST_W   = 11;
	localparam int ANGLE_W = 16;

	localparam int CX = IMAGE_WIDTH / 2;
	localparam int CY = IMAGE_HEIGHT / 2;

	// signed source offset, covers sizes up to 4096
	localparam int DX_W   = 14;
	localparam int PROD_W = DX_W + ANGLE_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int CRD_W  = ACC_W - FRAC_BITS;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_COS_ANGLE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SIN_ANGLE = 2'd1;

	localparam logic signed [ANGLE_W-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [ANGLE_W-1:0] SIN_RESET = 16'sd0;

	typedef struct packed {
		logic [SRC_W-1:0]   src_col;
		logic [SRC_W-1:0]   src_row;
		logic [COLOR_W-1:0] red_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] blue_in;
	} src_word_t;

	typedef struct packed {
		logic [DST_W-1:0]   dst_col;
		logic [DST_W-1:0]   dst_row;
		logic [COLOR_W-1:0] red_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] blue_out;
		logic               last_write;
	} dst_word_t;

	// one classified pixel: both corners per axis plus color
	typedef struct packed {
		logic [DST_W-1:0]   x_ceil;
		logic [DST_W-1:0]   x_floor;
		logic [DST_W-1:0]   y_ceil;
		logic [DST_W-1:0]   y_floor;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} corner_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/rtc_front.sv =====
// front end: accepts source words, rotates about the center, finds floor/ceil corners
// depends on rtc_pkg
module rtc_front
	import rtc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [ANGLE_W-1:0]   cos_q,
	input  logic signed [ANGLE_W-1:0]   sin_q,
	input  logic                        push,
	input  src_word_t                   src_word,
	output logic                        full,
	input  q_stat_t                     q_stat,
	output logic                        q_push,
	output corner_word_t                q_wdata
);

	localparam logic signed [ACC_W-1:0] CXQ = ACC_W'(CX) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] CYQ = ACC_W'(CY) <<< FRAC_BITS;

	logic adv;
	logic accept;
	logic signed [DX_W-1:0] dx;
	logic signed [DX_W-1:0] dy;

	logic v_s1, v_s2;
	logic signed [PROD_W-1:0] dxc_s1, dys_s1, dxs_s1, dyc_s1;
	logic [COLOR_W-1:0] red_s1, green_s1, blue_s1;
	logic signed [ACC_W-1:0] rx_s2, ry_s2;
	logic [COLOR_W-1:0] red_s2, green_s2, blue_s2;

	logic signed [CRD_W-1:0] xf, xc, yf, yc;

	// clamp onto the canvas 0 .. 3*size-1
	function automatic logic [DST_W-1:0] place(input logic signed [CRD_W-1:0] coord,
			input int size);
		logic signed [CRD_W:0] v;
		logic signed [CRD_W:0] hi;
		logic [DST_W-1:0] r;
		v  = (CRD_W+1)'(coord) + (CRD_W+1)'(size);
		hi = (CRD_W+1)'(3 * size - 1);
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi[DST_W-1:0];
		end else begin
			r = v[DST_W-1:0];
		end
		return r;
	endfunction

	assign adv    = !(v_s2 && q_stat.full);
	assign full   = !adv;
	assign accept = push && adv;

	assign dx = $signed({{(DX_W-SRC_W){1'b0}}, src_word.src_col}) - DX_W'(CX);
	assign dy = $signed({{(DX_W-SRC_W){1'b0}}, src_word.src_row}) - DX_W'(CY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dxc_s1   <= dx * cos_q;
			dys_s1   <= dy * sin_q;
			dxs_s1   <= dx * sin_q;
			dyc_s1   <= dy * cos_q;
			red_s1   <= src_word.red_in;
			green_s1 <= src_word.green_in;
			blue_s1  <= src_word.blue_in;
			rx_s2    <= ACC_W'(dxc_s1) - ACC_W'(dys_s1) + CXQ;
			ry_s2    <= ACC_W'(dxs_s1) + ACC_W'(dyc_s1) + CYQ;
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
		end
	end

	// arithmetic shift is floor, ceil adds one when a fraction remains
	assign xf = rx_s2[ACC_W-1:FRAC_BITS];
	assign yf = ry_s2[ACC_W-1:FRAC_BITS];
	assign xc = xf + CRD_W'(|rx_s2[FRAC_BITS-1:0]);
	assign yc = yf + CRD_W'(|ry_s2[FRAC_BITS-1:0]);

	assign q_push          = v_s2 && !q_stat.full;
	assign q_wdata.x_ceil  = place(xc, IMAGE_WIDTH);
	assign q_wdata.x_floor = place(xf, IMAGE_WIDTH);
	assign q_wdata.y_ceil  = place(yc, IMAGE_HEIGHT);
	assign q_wdata.y_floor = place(yf, IMAGE_HEIGHT);
	assign q_wdata.red     = red_s2;
	assign q_wdata.green   = green_s2;
	assign q_wdata.blue    = blue_s2;

endmodule

// ===== sv/rtc_fifo.sv =====
// short queue between front and back ends
// depends on rtc_pkg
module rtc_fifo
	import rtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  corner_word_t wdata,
	input  logic         pop,
	output corner_word_t rdata,
	output q_stat_t      stat
);

	corner_word_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign stat.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== sv/rtc_back.sv =====
// back end: expands each queued pixel into four canvas writes
// depends on rtc_pkg
module rtc_back
	import rtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  corner_word_t q_rdata,
	input  q_stat_t      q_stat,
	output logic         q_pop,
	input  logic         pop,
	output logic         empty,
	output dst_word_t    dst_word
);

	typedef enum logic [1:0] {
		CORNER_CC,
		CORNER_CF,
		CORNER_FC,
		CORNER_FF
	} corner_t;

	corner_t   k_q;
	logic      ov_q;
	logic      slot_free;
	logic      load;
	dst_word_t word_q;
	dst_word_t next_word;

	assign slot_free = !ov_q || pop;
	assign load      = slot_free && !q_stat.empty;
	assign q_pop     = load && (k_q == CORNER_FF);
	assign empty     = !ov_q;
	assign dst_word  = word_q;

	always_comb begin
		next_word.red_out    = q_rdata.red;
		next_word.green_out  = q_rdata.green;
		next_word.blue_out   = q_rdata.blue;
		next_word.last_write = (k_q == CORNER_FF);
		case (k_q)
			CORNER_CC: begin
				next_word.dst_col = q_rdata.x_ceil;
				next_word.dst_row = q_rdata.y_ceil;
			end
			CORNER_CF: begin
				next_word.dst_col = q_rdata.x_ceil;
				next_word.dst_row = q_rdata.y_floor;
			end
			CORNER_FC: begin
				next_word.dst_col = q_rdata.x_floor;
				next_word.dst_row = q_rdata.y_ceil;
			end
			default: begin
				next_word.dst_col = q_rdata.x_floor;
				next_word.dst_row = q_rdata.y_floor;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			k_q  <= CORNER_CC;
		end else if (slot_free) begin
			ov_q <= !q_stat.empty;
			if (!q_stat.empty) k_q <= corner_t'(k_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) word_q <= next_word;
	end

endmodule

// ===== sv/rotate_about_center_splat_core.sv =====
// top level of the rotate-about-center splat core
// holds the angle registers and ties front, queue and back together
// depends on rtc_pkg, rtc_front, rtc_fifo, rtc_back
//
//   channel   handshake        payload               accepted when
//   source    push / full      src_word (src_word_t) push && !full
//   result    empty / pop      dst_word (dst_word_t) pop && !empty
//   config    cfg_we           cfg_addr, cfg_wdata   cfg_we
//
// one source word gives four result words, one per cycle from the back end's
// output register while pop is high and the queue holds a pixel
// an accepted word passes two front stages and a queue write, then the first
// result word loads into the back end's output register; the rest follow while pop is high
// reset clears pipeline valids, queue pointers and the corner counter;
// cos resets to 1.0 and sin to 0
// a stalled result side fills the four-deep queue, then the front holds and full rises

module rotate_about_center_splat_core
	import rtc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ANGLE_W-1:0]     cfg_wdata,
	input  logic                   push,
	input  src_word_t              src_word,
	output logic                   full,
	output logic                   empty,
	input  logic                   pop,
	output dst_word_t              dst_word
);

	// angle registers, signed q2.14
	logic signed [ANGLE_W-1:0] cos_q;
	logic signed [ANGLE_W-1:0] sin_q;

	// queue between front and back
	logic         q_push;
	logic         q_pop;
	corner_word_t q_wdata;
	corner_word_t q_rdata;
	q_stat_t      q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= SIN_RESET;
		end else if (cfg_we) begin
			// unknown indexes are dropped
			case (cfg_addr)
				REG_COS_ANGLE: cos_q <= $signed(cfg_wdata);
				REG_SIN_ANGLE: sin_q <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// front: offset from center, four products, sums, floor/ceil and canvas clamp
	rtc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cos_q    (cos_q),
		.sin_q    (sin_q),
		.push     (push),
		.src_word (src_word),
		.full     (full),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// up to four classified pixels queued between the two sides
	rtc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// back: walks ceil-ceil, ceil-floor, floor-ceil, floor-floor into the output register
	rtc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.dst_word (dst_word)
	);

	// front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	// back only retires a pixel that is queued
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// a retired pixel always leaves with its last word
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (!empty && dst_word.last_write))
		else $error("pixel retired without last word");

endmodule
